@@ rtl/ahbr_pkg.sv @@
// ----------------------------------------------------------------------------
// ahbr_pkg
// Shared types, constants, microcode table and helpers of the allpass
// half-band resampler.
// ----------------------------------------------------------------------------
package ahbr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int WORD_W    = 32;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = WORD_W + COEF_W + 1;
    localparam int RAM_DEPTH = 8;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int PC_W      = 4;
    localparam int SCALE_SH  = 10;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_POST,
        OP_EMIT_DN
    } uop_t;

    typedef struct packed {
        logic       rd_en;
        logic       rd_lower;
        logic [1:0] rd_addr;
        logic       ld_d;
        logic       mul;
        logic       wr_in;
        logic       acc;
        logic       wr_res;
        logic [1:0] wr_addr;
        logic [1:0] sec;
        uop_t       op;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic   start;
        logic   hold;
        logic   jump;
        logic   done;
    } seq_ctl_t;

    typedef struct packed {
        logic   start;
        logic   reload;
        logic   bank;
        ucode_t uw;
    } dp_ctl_t;

    localparam logic [PC_W-1:0] PC_CHAIN = 4'd0;

    // one section takes three steps; the read for the next section overlaps
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            4'd0: begin
                w.rd_en = 1'b1; w.rd_addr = 2'd1;
            end
            4'd1: begin
                w.ld_d = 1'b1; w.rd_en = 1'b1; w.rd_addr = 2'd0;
            end
            4'd2: begin
                w.mul = 1'b1; w.sec = 2'd0; w.wr_in = 1'b1; w.wr_addr = 2'd0;
            end
            4'd3: begin
                w.acc = 1'b1; w.rd_en = 1'b1; w.rd_addr = 2'd2;
            end
            4'd4: begin
                w.ld_d = 1'b1; w.rd_en = 1'b1; w.rd_addr = 2'd1;
            end
            4'd5: begin
                w.mul = 1'b1; w.sec = 2'd1; w.wr_in = 1'b1; w.wr_addr = 2'd1;
            end
            4'd6: begin
                w.acc = 1'b1; w.rd_en = 1'b1; w.rd_addr = 2'd3;
            end
            4'd7: begin
                w.ld_d = 1'b1; w.rd_en = 1'b1; w.rd_addr = 2'd2;
            end
            4'd8: begin
                w.mul = 1'b1; w.sec = 2'd2; w.wr_in = 1'b1; w.wr_addr = 2'd2;
            end
            4'd9: begin
                w.acc = 1'b1; w.wr_res = 1'b1; w.wr_addr = 2'd3;
            end
            4'd10: begin
                // fetch lower chain output word for the decimated sum
                w.op = OP_POST; w.target = PC_CHAIN;
                w.rd_en = 1'b1; w.rd_lower = 1'b1; w.rd_addr = 2'd3;
            end
            4'd11: begin
                w.op = OP_EMIT_DN;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // set_b selects the 12199/37471/60255 set
    function automatic logic [COEF_W-1:0] coef_sel(input logic set_b, input logic [1:0] sec);
        logic [COEF_W-1:0] c;
        case ({set_b, sec})
            3'b000:  c = 16'd3284;
            3'b001:  c = 16'd24441;
            3'b010:  c = 16'd49528;
            3'b100:  c = 16'd12199;
            3'b101:  c = 16'd37471;
            3'b110:  c = 16'd60255;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [22:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 23'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -23'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/ahbr_ram.sv @@
// ----------------------------------------------------------------------------
// ahbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ahbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ahbr_seq.sv @@
// ----------------------------------------------------------------------------
// ahbr_seq
// Step counter and microcode table; advances, jumps, holds or finishes per step.
// ----------------------------------------------------------------------------
module ahbr_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  ahbr_pkg::seq_ctl_t ctl,
    output ahbr_pkg::ucode_t  uw,
    output logic              busy
);
    import ahbr_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            busy_reg, busy_next;

    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (ctl.start) begin
            pc_next   = PC_CHAIN;
            busy_next = 1'b1;
        end else if (busy_reg && !ctl.hold) begin
            if (ctl.done) begin
                busy_next = 1'b0;
            end else if (ctl.jump) begin
                pc_next = uw.target;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= PC_CHAIN;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign uw   = ucode_rom(pc_reg);
    assign busy = busy_reg;

endmodule

@@ rtl/ahbr_dp.sv @@
// ----------------------------------------------------------------------------
// ahbr_dp
// Filter datapath: state RAM, one shared multiplier, accumulator and
// output rounding.
// ----------------------------------------------------------------------------
module ahbr_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  mode,
    input  ahbr_pkg::dp_ctl_t                     ctl,
    input  logic signed [ahbr_pkg::SAMPLE_W-1:0]  sample,
    output logic signed [ahbr_pkg::SAMPLE_W-1:0]  up_val,
    output logic signed [ahbr_pkg::SAMPLE_W-1:0]  dn_val
);
    import ahbr_pkg::*;

    logic [WORD_W-1:0]        x_reg, in_reg, d_reg, c_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [RAM_DEPTH-1:0]     valid_reg;
    logic                     rd_ok_reg;

    logic [RAM_AW-1:0]        rd_idx, wr_idx;
    logic [WORD_W-1:0]        ram_q, rd_word, acc_sum, wdata, scaled;
    logic [COEF_W-1:0]        coef;
    logic                     we;
    logic signed [WORD_W:0]   up_sum;
    logic signed [WORD_W+1:0] dn_sum;

    assign scaled  = {{(WORD_W-SAMPLE_W-SCALE_SH){sample[SAMPLE_W-1]}}, sample,
                      {SCALE_SH{1'b0}}};
    assign rd_idx  = {(ctl.uw.rd_lower ? 1'b0 : ctl.bank), ctl.uw.rd_addr};
    assign wr_idx  = {ctl.bank, ctl.uw.wr_addr};
    assign we      = ctl.uw.wr_in | ctl.uw.wr_res;
    assign acc_sum = c_reg + prod_reg[WORD_W+COEF_W-1:COEF_W];
    assign wdata   = ctl.uw.wr_res ? acc_sum : in_reg;
    // words never written read as cleared
    assign rd_word = rd_ok_reg ? ram_q : '0;
    // upper chain in interpolation and lower chain in decimation use set b
    assign coef    = coef_sel(ctl.bank ^ mode, ctl.uw.sec);

    ahbr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (wr_idx),
        .wdata (wdata),
        .re    (ctl.uw.rd_en),
        .raddr (rd_idx),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.uw.rd_en) begin
            rd_ok_reg <= valid_reg[rd_idx];
        end
        if (ctl.start) begin
            x_reg  <= scaled;
            in_reg <= scaled;
        end else if (ctl.reload) begin
            in_reg <= x_reg;
        end else if (ctl.uw.acc) begin
            in_reg <= acc_sum;
        end
        if (ctl.uw.ld_d) begin
            d_reg <= in_reg - rd_word;
        end
        if (ctl.uw.mul) begin
            prod_reg <= $signed(d_reg) * $signed({1'b0, coef});
            c_reg    <= rd_word;
        end
    end

    assign up_sum = $signed({in_reg[WORD_W-1], in_reg}) + 33'sd512;
    assign dn_sum = $signed({{2{rd_word[WORD_W-1]}}, rd_word})
                  + $signed({{2{in_reg[WORD_W-1]}}, in_reg}) + 34'sd1024;
    assign up_val = sat16(up_sum[WORD_W:10]);
    assign dn_val = sat16(dn_sum[WORD_W+1:11]);

endmodule

@@ rtl/allpass_halfband_resampler_by2_top.sv @@
// ----------------------------------------------------------------------------
// allpass_halfband_resampler_by2_top
// Polyphase allpass half-band resampler by two for 16-bit audio.
// ----------------------------------------------------------------------------
// Input samples arrive on the s_ stream, tlast marking the end of a caller's
// buffer; results leave on the m_ stream, tlast set on the final result of
// an input. cfg_wr_en/cfg_wr_data select interpolation (0) or decimation (1)
// and restart the decimation pairing; write it only while idle.
// One input is worked on at a time by a microcoded sequencer driving a single
// multiplier and one RAM read port, three steps per allpass section.
// Interpolate: two results per input, the first from the lower chain and the second
// from the upper chain. Decimate: one result per pair of samples, produced after
// the second sample of the pair. A lone trailing sample flagged by tlast is taken
// and dropped.
// A result waits in the output register while the next input is taken; if
// the receiver stalls, the sequencer holds at the next result step.
// Reset clears the filter words, mode and pairing phase.
// ----------------------------------------------------------------------------
module allpass_halfband_resampler_by2_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [15:0] sample
    input  logic        s_tlast,        // block_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,        // [15:0] out_sample
    output logic        m_tlast         // last
);
    import ahbr_pkg::*;

    logic mode_reg, phase_reg, bank_reg;
    logic out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic out_last_reg;

    ucode_t   uw_raw, uw_run;
    seq_ctl_t sctl;
    dp_ctl_t  dctl;
    logic     busy, accept, drop, start, need_out, stall, run, emit;
    logic     is_post, is_emit_dn;
    logic signed [SAMPLE_W-1:0] up_val, dn_val;

    assign s_tready   = !busy;
    assign accept     = s_tvalid && s_tready;
    // odd sample at the end of a buffer in decimation
    assign drop       = mode_reg && !phase_reg && s_tlast;
    assign start      = accept && !drop;
    assign is_post    = (uw_raw.op == OP_POST);
    assign is_emit_dn = (uw_raw.op == OP_EMIT_DN);
    assign need_out   = (is_post && !mode_reg) || is_emit_dn;
    assign stall      = busy && need_out && out_valid_reg && !m_tready;
    assign run        = busy && !stall;
    assign emit       = run && need_out;
    assign uw_run     = run ? uw_raw : '0;

    always_comb begin
        sctl.start = start;
        sctl.hold  = stall;
        sctl.jump  = is_post && !mode_reg && !bank_reg;
        sctl.done  = is_emit_dn || (is_post && (mode_reg ? !bank_reg : bank_reg));
    end

    always_comb begin
        dctl.start  = start;
        dctl.reload = run && is_post && !mode_reg && !bank_reg;
        dctl.bank   = bank_reg;
        dctl.uw     = uw_run;
    end

    ahbr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sctl),
        .uw      (uw_raw),
        .busy    (busy)
    );

    ahbr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mode    (mode_reg),
        .ctl     (dctl),
        .sample  (s_tdata),
        .up_val  (up_val),
        .dn_val  (dn_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg  <= cfg_wr_data;
                phase_reg <= 1'b0;
            end else if (run && is_post && mode_reg && !bank_reg) begin
                phase_reg <= 1'b1;
            end else if (run && is_emit_dn) begin
                phase_reg <= 1'b0;
            end
            if (start) begin
                bank_reg <= mode_reg && phase_reg;
            end else if (dctl.reload) begin
                bank_reg <= 1'b1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_sample_reg <= is_emit_dn ? dn_val : up_val;
            out_last_reg   <= is_emit_dn || bank_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !(out_valid_reg && !m_tready))
        else $error("result register overwritten");

    // decimation yields a result only on the second sample of a pair
    a_dn_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && mode_reg) |-> (phase_reg && bank_reg))
        else $error("decimated result out of phase");

    // an interpolated pair ends the item once the upper result is loaded for output
    a_up_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (run && is_post && !mode_reg && bank_reg) |=> (!busy && m_tvalid && m_tlast))
        else $error("interpolation did not finish after upper result");

    // a started item keeps the sequencer busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (busy && !s_tready))
        else $error("sequencer not busy after start");

endmodule
